// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is low
`define TLRS_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) else $error(msg);

// clocked assertion that also holds during reset
`define TLRS_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== rtl/tlrs_pkg.sv =====
// types, constants and helpers of the tolerant level run segmenter
package tlrs_pkg;

    localparam int INDEX_BITS = 32;
    localparam int POS_W      = 32;
    localparam int RUN_W      = 32;
    localparam int CORR_W     = 33;
    localparam int ERR_W      = 33;
    localparam int SMP_W      = 11;
    localparam int RAW_W      = 16;
    localparam int GAP_W      = INDEX_BITS + 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_STEPS  = RUN_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [SMP_W-1:0] CLAMP_MAX = 11'd1200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UPPER  = 3'd0,
        CFG_LOWER  = 3'd1,
        CFG_MINRUN = 3'd2,
        CFG_ALLOW  = 3'd3,
        CFG_CORR   = 3'd4,
        CFG_MERGE  = 3'd5,
        CFG_FIRST  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic              start;
        logic [RUN_W-1:0]  dividend;
        logic [CORR_W-1:0] divisor;
    } mod_req_t;

    typedef struct packed {
        logic done;
        logic rem_zero;
    } mod_rsp_t;

    typedef struct packed {
        logic [POS_W-1:0] seg_start;
        logic [POS_W-1:0] seg_end;
        logic             no_segment;
        logic             record_done;
    } out_item_t;

    function automatic logic [POS_W-1:0] pos_out(input logic [INDEX_BITS-1:0] x);
        logic [63:0] w;
        w = 64'(x);
        return w[POS_W-1:0];
    endfunction

endpackage

// ===== rtl/tlrs_mod_unit.sv =====
// shared restoring remainder unit, one quotient bit per cycle
module tlrs_mod_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  tlrs_pkg::mod_req_t req,
    output tlrs_pkg::mod_rsp_t rsp
);
    import tlrs_pkg::*;

    logic [CORR_W-1:0]    rem_reg, rem_next;
    logic [RUN_W-1:0]     dvd_reg, dvd_next;
    logic [CORR_W-1:0]    div_reg, div_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [CORR_W:0]      trial;

    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {rem_reg, dvd_reg[RUN_W-1]};
        if (req.start)
        begin
            rem_next = '0;
            dvd_next = req.dividend;
            div_next = req.divisor;
            cnt_next = DIV_CNT_W'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = CORR_W'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[CORR_W-1:0];
            end
            dvd_next = {dvd_reg[RUN_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        div_reg <= div_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.rem_zero = (rem_reg == '0);

endmodule

// ===== rtl/tlrs_out_fifo.sv =====
// two-entry result queue between the sequencer and the output channel
module tlrs_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tlrs_pkg::out_item_t push_item,
    output logic                full,
    input  logic                pop,
    output logic                not_empty,
    output tlrs_pkg::out_item_t head
);
    import tlrs_pkg::*;

    out_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/tolerant_level_run_segmenter.sv =====
// top level: sample sequencer, run state and configuration registers
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | tdata: sample; tlast: last_sample
//  m_      | out       | m_tvalid/m_tready  | tdata: seg_start, seg_end;
//          |           |                    | tuser: no_segment; tlast: record_done
//  cfg_    | in        | cfg_we             | cfg_index, cfg_wdata
//
//  an in-band or absorbed sample passes through accept, evaluate, the 32 steps of the
//  shared remainder unit and its done flag, forgive and queue; other samples go from
//  evaluate to queue; a record's last item then adds a state for its closing result
//  results pass through a two-entry queue, so the next item is taken while one waits
//  a full queue holds the sequencer in its push states until the output side drains
//  reset clears all run state; configuration resets to its default values
module tolerant_level_run_segmenter (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [15:0]                      s_tdata,   // sample
    input  logic                             s_tlast,   // last_sample
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [63:0]                      m_tdata,   // seg_start, seg_end
    output logic                             m_tuser,   // no_segment
    output logic                             m_tlast,   // record_done
    input  logic                             cfg_we,
    input  logic [tlrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tlrs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import tlrs_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_EVAL   = 6'b000010,
        ST_DIV    = 6'b000100,
        ST_APPLY  = 6'b001000,
        ST_PUSH_A = 6'b010000,
        ST_PUSH_B = 6'b100000
    } state_t;

    localparam logic [RUN_W-1:0]  RUN_MAX  = {RUN_W{1'b1}};
    localparam logic [CORR_W-1:0] CORR_MAX = {CORR_W{1'b1}};
    localparam logic [ERR_W-1:0]  ERR_MIN  = {1'b1, {(ERR_W-1){1'b0}}};

    state_t state_reg, state_next;

    logic [10:0]     upper_reg;
    logic [11:0]     lower_reg;
    logic [15:0]     minrun_reg, allow_reg, corr_start_reg, merge_reg;
    logic [31:0]     first_reg;

    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic                  in_run_reg, in_run_next;
    logic [RUN_W-1:0]      run_reg, run_next;
    logic [CORR_W-1:0]     corr_reg, corr_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic [RUN_W-1:0]      streak_reg, streak_next;
    logic [INDEX_BITS-1:0] run_start_reg, run_start_next;
    logic                  held_reg, held_next;
    logic [INDEX_BITS-1:0] held_start_reg, held_start_next;
    logic [INDEX_BITS-1:0] held_end_reg, held_end_next;
    logic                  emit_a_reg, emit_a_next;
    logic [INDEX_BITS-1:0] a_start_reg, a_start_next;
    logic [INDEX_BITS-1:0] a_end_reg, a_end_next;
    logic [SMP_W-1:0]      smp_reg, smp_next;
    logic                  last_reg, last_next;

    logic                  s_fire;
    logic signed [RAW_W-1:0] raw;
    logic [SMP_W-1:0]      clamped;
    logic                  in_band, absorb, close_ok, merge_ok;
    logic [RUN_W-1:0]      run_inc;
    logic [CORR_W-1:0]     corr_eff;
    logic [INDEX_BITS-1:0] end_pos;
    logic signed [GAP_W-1:0] gap;
    logic                  hit;

    mod_req_t  mod_req;
    mod_rsp_t  mod_rsp;
    out_item_t push_item, head;
    logic      push, fifo_full, fifo_not_empty;

    tlrs_mod_unit u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    tlrs_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (fifo_full),
        .pop       (m_tready),
        .not_empty (fifo_not_empty),
        .head      (head)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = fifo_not_empty;
    assign m_tdata  = {head.seg_end, head.seg_start};
    assign m_tuser  = head.no_segment;
    assign m_tlast  = head.record_done;

    // clamp to 0..1200
    assign raw = $signed(s_tdata);
    always_comb
    begin
        priority if (raw < 0)
        begin
            clamped = '0;
        end
        else if (raw > $signed({5'b0, CLAMP_MAX}))
        begin
            clamped = CLAMP_MAX;
        end
        else
        begin
            clamped = raw[SMP_W-1:0];
        end
    end

    assign corr_eff = (idx_reg == '0) ? CORR_W'(corr_start_reg) : corr_reg;
    assign run_inc  = (run_reg == RUN_MAX) ? run_reg : run_reg + 1'b1;
    assign in_band  = (smp_reg < upper_reg) &&
                      ($signed({2'b00, smp_reg}) > $signed({lower_reg[11], lower_reg}));
    assign absorb   = in_run_reg && (err_reg < $signed(ERR_W'(allow_reg)));
    assign close_ok = in_run_reg && ((run_reg >= RUN_W'(minrun_reg)) ||
                      (!held_reg && (run_reg >= first_reg)));
    assign end_pos  = idx_reg - INDEX_BITS'(streak_reg);
    assign gap      = $signed({2'b00, run_start_reg}) - $signed({2'b00, held_end_reg});
    assign merge_ok = held_reg && (gap < $signed(GAP_W'(merge_reg)));
    assign hit      = (corr_reg != '0) && (run_reg >= RUN_W'(minrun_reg)) &&
                      ({1'b0, run_reg} >= corr_reg) && mod_rsp.rem_zero;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        in_run_next     = in_run_reg;
        run_next        = run_reg;
        corr_next       = corr_reg;
        err_next        = err_reg;
        streak_next     = streak_reg;
        run_start_next  = run_start_reg;
        held_next       = held_reg;
        held_start_next = held_start_reg;
        held_end_next   = held_end_reg;
        emit_a_next     = emit_a_reg;
        a_start_next    = a_start_reg;
        a_end_next      = a_end_reg;
        smp_next        = smp_reg;
        last_next       = last_reg;
        mod_req.start    = 1'b0;
        mod_req.dividend = run_inc;
        mod_req.divisor  = corr_eff;
        push             = 1'b0;
        push_item.seg_start   = pos_out(held_start_reg);
        push_item.seg_end     = pos_out(held_end_reg);
        push_item.no_segment  = 1'b0;
        push_item.record_done = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    smp_next   = clamped;
                    last_next  = s_tlast;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                emit_a_next = 1'b0;
                corr_next   = corr_eff;
                idx_next    = idx_reg + 1'b1;
                state_next  = ST_PUSH_A;
                priority if (in_band)
                begin
                    if (!in_run_reg)
                    begin
                        run_start_next = idx_reg;
                        in_run_next    = 1'b1;
                    end
                    run_next    = run_inc;
                    corr_next   = (corr_eff == CORR_MAX) ? corr_eff : corr_eff + 1'b1;
                    streak_next = '0;
                    mod_req.start   = 1'b1;
                    mod_req.divisor = (corr_eff == CORR_MAX) ? corr_eff : corr_eff + 1'b1;
                    state_next  = ST_DIV;
                end
                else if (absorb)
                begin
                    run_next    = run_inc;
                    err_next    = err_reg + 1'b1;
                    streak_next = (streak_reg == RUN_MAX) ? streak_reg : streak_reg + 1'b1;
                    mod_req.start = 1'b1;
                    state_next  = ST_DIV;
                end
                else if (close_ok)
                begin
                    in_run_next = 1'b0;
                    if (merge_ok)
                    begin
                        held_end_next = end_pos;
                    end
                    else
                    begin
                        emit_a_next     = held_reg;
                        a_start_next    = held_start_reg;
                        a_end_next      = held_end_reg;
                        held_next       = 1'b1;
                        held_start_next = run_start_reg;
                        held_end_next   = end_pos;
                    end
                    run_next    = '0;
                    err_next    = '0;
                    streak_next = '0;
                end
                else if (in_run_reg)
                begin
                    in_run_next = 1'b0;
                    run_next    = '0;
                    err_next    = '0;
                    streak_next = '0;
                end
                else
                begin
                    in_run_next = in_run_reg;
                end
            end
            ST_DIV:
            begin
                if (mod_rsp.done)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (hit && (err_reg != $signed(ERR_MIN)))
                begin
                    err_next = err_reg - 1'b1;
                end
                state_next = ST_PUSH_A;
            end
            ST_PUSH_A:
            begin
                push_item.seg_start   = pos_out(a_start_reg);
                push_item.seg_end     = pos_out(a_end_reg);
                push_item.record_done = 1'b0;
                if (!emit_a_reg || !fifo_full)
                begin
                    push        = emit_a_reg;
                    emit_a_next = 1'b0;
                    state_next  = last_reg ? ST_PUSH_B : ST_IDLE;
                end
            end
            ST_PUSH_B:
            begin
                if (!held_reg)
                begin
                    push_item.seg_start  = '0;
                    push_item.seg_end    = '0;
                    push_item.no_segment = 1'b1;
                end
                if (!fifo_full)
                begin
                    push            = 1'b1;
                    idx_next        = '0;
                    in_run_next     = 1'b0;
                    run_next        = '0;
                    corr_next       = CORR_W'(corr_start_reg);
                    err_next        = '0;
                    streak_next     = '0;
                    run_start_next  = '0;
                    held_next       = 1'b0;
                    held_start_next = '0;
                    held_end_next   = '0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            in_run_reg     <= 1'b0;
            run_reg        <= '0;
            corr_reg       <= CORR_W'(50);
            err_reg        <= '0;
            streak_reg     <= '0;
            run_start_reg  <= '0;
            held_reg       <= 1'b0;
            held_start_reg <= '0;
            held_end_reg   <= '0;
            emit_a_reg     <= 1'b0;
            last_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            in_run_reg     <= in_run_next;
            run_reg        <= run_next;
            corr_reg       <= corr_next;
            err_reg        <= err_next;
            streak_reg     <= streak_next;
            run_start_reg  <= run_start_next;
            held_reg       <= held_next;
            held_start_reg <= held_start_next;
            held_end_reg   <= held_end_next;
            emit_a_reg     <= emit_a_next;
            last_reg       <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smp_reg     <= smp_next;
        a_start_reg <= a_start_next;
        a_end_reg   <= a_end_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg      <= 11'd1201;
            lower_reg      <= 12'hFFF;
            minrun_reg     <= 16'd50;
            allow_reg      <= 16'd5;
            corr_start_reg <= 16'd50;
            merge_reg      <= 16'd500;
            first_reg      <= 32'd50;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_UPPER:  upper_reg      <= cfg_wdata[10:0];
                CFG_LOWER:  lower_reg      <= cfg_wdata[11:0];
                CFG_MINRUN: minrun_reg     <= cfg_wdata[15:0];
                CFG_ALLOW:  allow_reg      <= cfg_wdata[15:0];
                CFG_CORR:   corr_start_reg <= cfg_wdata[15:0];
                CFG_MERGE:  merge_reg      <= cfg_wdata[15:0];
                CFG_FIRST:  first_reg      <= cfg_wdata[31:0];
                default:    upper_reg      <= upper_reg;
            endcase
        end
    end

endmodule

// ===== rtl/tlrs_checker.sv =====
// port-level checks of the segmenter and their binding
`include "assert_macros.svh"

module tlrs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast
);

    logic        s_take;
    logic        m_stall;
    logic        m_mark;
    logic [66:0] m_word;

    assign s_take  = s_tvalid && s_tready;
    assign m_stall = m_tvalid && !m_tready;
    assign m_mark  = m_tvalid && m_tuser;
    assign m_word  = {m_tvalid, m_tdata, m_tuser, m_tlast};

    // a no-segment marker closes the record
    `TLRS_ASSERT(a_marker_done, clk, rst_n, m_mark |-> m_tlast, "marker without record_done")

    // a no-segment marker carries zero positions
    `TLRS_ASSERT(a_marker_zero, clk, rst_n, m_mark |-> (m_tdata == 64'd0), "marker with positions")

    // the sequencer is busy right after an item is taken
    `TLRS_ASSERT(a_busy_after, clk, rst_n, s_take |=> !s_tready, "ready right after accept")

    // a stalled result holds
    `TLRS_ASSERT(a_out_hold, clk, rst_n, m_stall |=> $stable(m_word), "stalled result changed")

    // nothing is offered once reset has been seen low
    `TLRS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !m_tvalid, "result offered in reset")

endmodule

bind tolerant_level_run_segmenter tlrs_checker u_tlrs_checker (.*);

// ===== verif/tolerant_level_run_segmenter_tb.sv =====
// testbench of the tolerant level run segmenter: predicts segments and checks each result item
module tolerant_level_run_segmenter_tb;
    import tlrs_pkg::*;

    localparam longint SAT32   = 64'h0000_0000_FFFF_FFFF;
    localparam longint SAT33   = 64'h0000_0001_FFFF_FFFF;
    localparam longint ERR_MIN = -64'sd4294967296;
    localparam int SETTLE_CYCLES = 80;
    localparam int TIMEOUT = 5_000_000;
    localparam int PHASES = 28;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // sample
    logic        s_tlast;   // last_sample
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // seg_start, seg_end
    logic        m_tuser;   // no_segment
    logic        m_tlast;   // record_done
    logic        cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    tolerant_level_run_segmenter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor copy of the registers
    longint lvl_upper, lvl_lower, run_min, err_allow, corr_init, merge_gap, first_min;
    // predictor copy of the run state
    logic [31:0] smp_idx, run_begin, hold_begin, hold_end;
    logic        running, holding;
    longint      run_len, corr_cnt, err_cnt, err_run;

    out_item_t seg_expect_q[$];

    int src_gap_max;
    int snk_gap_max;
    int bad_count;
    int items_sent;
    int results_seen;
    int records_sent;
    int settings_used;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    task automatic clear_run_state();
        smp_idx    = '0;
        running    = 1'b0;
        run_len    = 0;
        corr_cnt   = corr_init;
        err_cnt    = 0;
        err_run    = 0;
        run_begin  = '0;
        holding    = 1'b0;
        hold_begin = '0;
        hold_end   = '0;
    endtask

    task automatic push_segment(input logic [31:0] s, input logic [31:0] e,
                                input logic none, input logic done);
        out_item_t it;
        it.seg_start   = s;
        it.seg_end     = e;
        it.no_segment  = none;
        it.record_done = done;
        seg_expect_q.push_back(it);
    endtask

    task automatic forgive_error();
        if (corr_cnt != 0 && run_len >= run_min && run_len >= corr_cnt &&
            (run_len % corr_cnt) == 0 && err_cnt > ERR_MIN)
        begin
            err_cnt = err_cnt - 1;
        end
    endtask

    task automatic predict_segments(input logic [15:0] raw, input logic last);
        longint      s;
        logic [31:0] i;
        logic [31:0] seg_last;
        s = longint'($signed(raw));
        if (s > 1200)
            s = 1200;
        if (s < 0)
            s = 0;
        if (smp_idx == 0)
            corr_cnt = corr_init;
        i = smp_idx;
        if (s < lvl_upper && s > lvl_lower)
        begin
            if (!running)
            begin
                run_begin = i;
                running   = 1'b1;
            end
            if (run_len < SAT32)
                run_len = run_len + 1;
            if (corr_cnt < SAT33)
                corr_cnt = corr_cnt + 1;
            err_run = 0;
            forgive_error();
        end
        else if (running && err_cnt < err_allow)
        begin
            if (run_len < SAT32)
                run_len = run_len + 1;
            err_cnt = err_cnt + 1;
            if (err_run < SAT32)
                err_run = err_run + 1;
            forgive_error();
        end
        else if (running && (run_len >= run_min || (!holding && run_len >= first_min)))
        begin
            seg_last = i - err_run[31:0];
            running  = 1'b0;
            if (holding && (longint'({32'd0, run_begin}) - longint'({32'd0, hold_end}))
                < merge_gap)
            begin
                hold_end = seg_last;
            end
            else
            begin
                if (holding)
                    push_segment(hold_begin, hold_end, 1'b0, 1'b0);
                holding    = 1'b1;
                hold_begin = run_begin;
                hold_end   = seg_last;
            end
            run_len = 0;
            err_cnt = 0;
            err_run = 0;
        end
        else if (running)
        begin
            running = 1'b0;
            run_len = 0;
            err_cnt = 0;
            err_run = 0;
        end
        smp_idx = i + 32'd1;
        if (last)
        begin
            if (holding)
                push_segment(hold_begin, hold_end, 1'b0, 1'b1);
            else
                push_segment('0, '0, 1'b1, 1'b1);
            clear_run_state();
        end
    endtask

    task automatic send_item(input logic [15:0] raw, input logic last);
        int gap;
        gap = $urandom_range(src_gap_max, 0);
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= raw;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        predict_segments(raw, last);
        items_sent++;
        if (last)
            records_sent++;
    endtask

    task automatic go_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (seg_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_UPPER:  lvl_upper = longint'(val[10:0]);
            CFG_LOWER:  lvl_lower = longint'($signed(val[11:0]));
            CFG_MINRUN: run_min   = longint'(val[15:0]);
            CFG_ALLOW:  err_allow = longint'(val[15:0]);
            CFG_CORR:   corr_init = longint'(val[15:0]);
            CFG_MERGE:  merge_gap = longint'(val[15:0]);
            CFG_FIRST:  first_min = longint'(val);
            default:    ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic write_all_regs(input int up, input int lo, input int mr, input int al,
                                  input int co, input int mg, input logic [31:0] fr);
        write_reg(CFG_UPPER, up);
        write_reg(CFG_LOWER, lo);
        write_reg(CFG_MINRUN, mr);
        write_reg(CFG_ALLOW, al);
        write_reg(CFG_CORR, co);
        write_reg(CFG_MERGE, mg);
        write_reg(CFG_FIRST, fr);
        settings_used++;
    endtask

    // raw value that clamps to the given level, sometimes from far outside the clamp range
    function automatic logic [15:0] raw_for(input int s);
        if (s == 0 && $urandom_range(2, 0) == 0)
            return 16'(-int'($urandom_range(32768, 1)));
        if (s == 1200 && $urandom_range(2, 0) == 0)
            return 16'($urandom_range(32767, 1201));
        return 16'(s);
    endfunction

    function automatic logic [15:0] pick_sample(input bit want_band);
        int  lo, hi;
        bit  has_low, has_high, has_band;
        lo = (lvl_lower + 1 > 0) ? int'(lvl_lower) + 1 : 0;
        hi = (lvl_upper - 1 < 1200) ? int'(lvl_upper) - 1 : 1200;
        has_band = (lo <= hi);
        has_low  = (lvl_lower >= 0);
        has_high = (lvl_upper <= 1200);
        if ($urandom_range(11, 0) == 0)
            return 16'($urandom);
        if ((want_band && has_band) || (!has_low && !has_high))
            return raw_for($urandom_range(hi, lo));
        if (has_low && (!has_high || $urandom_range(1, 0) == 0))
            return raw_for($urandom_range(int'(lvl_lower), 0));
        return raw_for($urandom_range(1200, int'(lvl_upper)));
    endfunction

    // alternating bursts of in-band and out-of-band samples, last one closes the record
    task automatic send_record(input int n_items);
        int k, burst, run_cap, allow_cap;
        bit band;
        run_cap   = (run_min < 20) ? int'(run_min) : 20;
        allow_cap = (err_allow < 6) ? int'(err_allow) : 6;
        k = 0;
        band = 1'b1;
        while (k < n_items)
        begin
            if (band)
                burst = $urandom_range(run_cap + 3, 1);
            else
                burst = $urandom_range(allow_cap + 3, 1);
            repeat (burst)
            begin
                if (k < n_items)
                begin
                    k++;
                    send_item(pick_sample(band), k == n_items);
                end
            end
            band = !band;
        end
    endtask

    task automatic flag_bad(input string msg);
        bad_count++;
        if (bad_count <= 10)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (seg_expect_q.size() == 0)
            begin
                flag_bad($sformatf("unexpected item start=%0d end=%0d none=%0b done=%0b",
                                   m_tdata[31:0], m_tdata[63:32], m_tuser, m_tlast));
            end
            else
            begin
                want = seg_expect_q.pop_front();
                if (m_tdata[31:0] !== want.seg_start || m_tdata[63:32] !== want.seg_end ||
                    m_tuser !== want.no_segment || m_tlast !== want.record_done)
                begin
                    flag_bad($sformatf("expected start=%0d end=%0d none=%0b done=%0b, got start=%0d end=%0d none=%0b done=%0b",
                                       want.seg_start, want.seg_end, want.no_segment,
                                       want.record_done, m_tdata[31:0], m_tdata[63:32],
                                       m_tuser, m_tlast));
                end
            end
        end
    end

    initial
    begin
        int stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(snk_gap_max, 0);
            if (stall > 0)
            begin
                @(negedge clk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_tvalid && m_tready));
        end
    end

    task automatic test_default_extremes();
        // everything is in band by default, the short run is dropped at record end
        send_item(16'h8000, 1'b0);
        send_item(16'h7FFF, 1'b0);
        send_item(16'd0, 1'b0);
        send_item(16'd1200, 1'b0);
        send_item(16'd1201, 1'b0);
        send_item(16'hFFFF, 1'b0);
        send_item(16'd600, 1'b1);
        go_idle();
    endtask

    task automatic test_close_and_merge();
        write_all_regs(1000, 100, 3, 1, 2, 3, 2);
        send_item(16'd500, 1'b0);
        send_item(16'd500, 1'b0);
        send_item(16'd500, 1'b0);
        send_item(16'd500, 1'b0);
        send_item(16'd50, 1'b0);
        send_item(16'd2000, 1'b0);
        send_item(16'd500, 1'b0);
        send_item(16'd999, 1'b0);
        send_item(16'd101, 1'b0);
        send_item(16'd0, 1'b0);
        send_item(16'd0, 1'b0);
        send_item(16'd1000, 1'b0);
        send_item(16'd101, 1'b0);
        send_item(16'd101, 1'b0);
        send_item(16'd101, 1'b0);
        send_item(16'd100, 1'b0);
        send_item(16'd100, 1'b0);
        send_item(16'd500, 1'b1);
        go_idle();
    endtask

    task automatic test_random_records();
        int ph, up, lo, mr, al, co, mg;
        logic [31:0] fr;
        for (ph = 0; ph < PHASES; ph++)
        begin
            src_gap_max = (ph % 4 == 3) ? 0 : 13;
            snk_gap_max = (ph % 5 == 2) ? 0 : 13;
            up = $urandom_range(1201, 300);
            lo = int'($urandom_range(200, 0)) - 1;
            mr = $urandom_range(10, 1);
            al = $urandom_range(4, 0);
            co = $urandom_range(10, 1);
            mg = $urandom_range(25, 0);
            fr = $urandom_range(12, 0);
            case (ph)
                0: up = 0;
                1: lo = 1200;
                2:
                begin
                    up = 1201;
                    lo = -1;
                    mr = 1;
                end
                3:
                begin
                    mr = 65535;
                    fr = 32'hFFFF_FFFF;
                end
                4: al = 65535;
                5:
                begin
                    co = 65535;
                    mr = 1;
                end
                6: mg = 65535;
                7:
                begin
                    mg = 0;
                    al = 0;
                    co = 1;
                    mr = 1;
                    fr = 0;
                end
                8:
                begin
                    fr = 0;
                    mr = 65535;
                end
                default: ;
            endcase
            write_all_regs(up, lo, mr, al, co, mg, fr);
            send_record($urandom_range(24, 4));
            send_record($urandom_range(24, 4));
            go_idle();
        end
    endtask

    task automatic finish_run();
        go_idle();
        $display("covered %0d items in %0d records under %0d register settings",
                 items_sent, records_sent, settings_used);
        $display("checked %0d result items, %0d mismatches", results_seen, bad_count);
        if (bad_count == 0 && seg_expect_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        bad_count  = 0;
        items_sent = 0;
        results_seen  = 0;
        records_sent  = 0;
        settings_used = 1;
        src_gap_max = 13;
        snk_gap_max = 13;
        lvl_upper = 1201;
        lvl_lower = -1;
        run_min   = 50;
        err_allow = 5;
        corr_init = 50;
        merge_gap = 500;
        first_min = 50;
        clear_run_state();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_default_extremes();
        test_close_and_merge();
        test_random_records();
        finish_run();
    end

    initial
    begin
        #(TIMEOUT);
        $display("timeout with %0d result items outstanding", seg_expect_q.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/tlrs_pkg.sv
rtl/tlrs_mod_unit.sv
rtl/tlrs_out_fifo.sv
rtl/tolerant_level_run_segmenter.sv
rtl/tlrs_checker.sv
verif/tolerant_level_run_segmenter_tb.sv
